>>> rtl/core/pgqd_pkg.sv
// Shared types, constants and the sigmoid entry function for the plate grid quad decoder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package pgqd_pkg;

  localparam int GRID_DIM_MAX_DEF    = 64;
  localparam int SIGMOID_ENTRIES_DEF = 1024;
  localparam int CFG_AW              = 5;

  // Configuration register indexes
  localparam logic [2:0] REG_SIDE_SCALE = 3'd0;
  localparam logic [2:0] REG_MIN_CONF   = 3'd1;
  localparam logic [2:0] REG_LOGIT_MODE = 3'd2;
  localparam logic [2:0] REG_PPC_X      = 3'd3;
  localparam logic [2:0] REG_PPC_Y      = 3'd4;
  localparam logic [2:0] REG_MIN_BOX_W  = 3'd5;
  localparam logic [2:0] REG_MIN_BOX_H  = 3'd6;

  localparam logic [15:0] RST_SIDE_SCALE = 16'd1984;
  localparam logic [15:0] RST_MIN_CONF   = 16'd32768;
  localparam logic [15:0] RST_PPC        = 16'd4096;
  localparam logic [15:0] RST_MIN_BOX_W  = 16'd461;
  localparam logic [15:0] RST_MIN_BOX_H  = 16'd154;

  typedef struct packed {
    logic [15:0] side_scale;
    logic [15:0] min_confidence;
    logic        logit_mode;
    logic [15:0] ppc_x;
    logic [15:0] ppc_y;
    logic [15:0] min_box_w;
    logic [15:0] min_box_h;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_CONF, S_MUL, S_OFS, S_PLO, S_PHI, S_GATE, S_EMIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       look;
    logic       conf;
    logic       mul;
    logic       ofs;
    logic       plo;
    logic       phi;
    logic       gate;
    logic       emit;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } sts_t;

  // shift-and-subtract quotient of two non-negative values, elaboration only
  function automatic longint div_u(input longint dividend, input longint divisor);
    longint quo, rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((dividend >>> b) & 1);
      if (rem >= divisor) begin
        rem = rem - divisor;
        quo = quo | (longint'(1) <<< b);
      end
    end
    return quo;
  endfunction

  // Q2.30 evaluation of one sigmoid entry, elaboration only
  function automatic logic [15:0] sigmoid_entry(input longint i, input longint n);
    longint one, d, ad, a, u, term, sum, den, num;
    logic   neg;
    one  = longint'(1) << 30;
    d    = 2 * i + 1 - n;
    neg  = (d < 0);
    ad   = neg ? -d : d;
    a    = div_u(ad * 8 * one, n);
    u    = a >>> 4;
    term = one;
    sum  = one;
    for (int k = 1; k <= 8; k++) begin
      term = div_u(div_u(term * u, one), longint'(k));
      sum  = ((k & 1) == 1) ? sum - term : sum + term;
    end
    for (int k = 0; k < 4; k++) sum = (sum * sum) >>> 30;
    den = one + sum;
    num = neg ? sum : one;
    num = div_u(65536 * num + (den >>> 1), den);
    return (num > 65535) ? 16'hFFFF : num[15:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/pgqd_cfg.sv
// APB-style configuration register file for the plate grid quad decoder.
// Depends on pgqd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pgqd_cfg import pgqd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output cfg_t                   cfg
);

  cfg_t       cfg_r;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.side_scale     <= RST_SIDE_SCALE;
      cfg_r.min_confidence <= RST_MIN_CONF;
      cfg_r.logit_mode     <= 1'b1;
      cfg_r.ppc_x          <= RST_PPC;
      cfg_r.ppc_y          <= RST_PPC;
      cfg_r.min_box_w      <= RST_MIN_BOX_W;
      cfg_r.min_box_h      <= RST_MIN_BOX_H;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_SIDE_SCALE: cfg_r.side_scale     <= pwdata[15:0];
        REG_MIN_CONF:   cfg_r.min_confidence <= pwdata[15:0];
        REG_LOGIT_MODE: cfg_r.logit_mode     <= pwdata[0];
        REG_PPC_X:      cfg_r.ppc_x          <= pwdata[15:0];
        REG_PPC_Y:      cfg_r.ppc_y          <= pwdata[15:0];
        REG_MIN_BOX_W:  cfg_r.min_box_w      <= pwdata[15:0];
        REG_MIN_BOX_H:  cfg_r.min_box_h      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIDE_SCALE: prdata = {16'd0, cfg_r.side_scale};
      REG_MIN_CONF:   prdata = {16'd0, cfg_r.min_confidence};
      REG_LOGIT_MODE: prdata = {31'd0, cfg_r.logit_mode};
      REG_PPC_X:      prdata = {16'd0, cfg_r.ppc_x};
      REG_PPC_Y:      prdata = {16'd0, cfg_r.ppc_y};
      REG_MIN_BOX_W:  prdata = {16'd0, cfg_r.min_box_w};
      REG_MIN_BOX_H:  prdata = {16'd0, cfg_r.min_box_h};
      default:        prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/pgqd_ctrl.sv
// Sequencer for the plate grid quad decoder: steps one cell through lookup,
// eight corner passes, the box gate and the result transfer. Depends on pgqd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pgqd_ctrl import pgqd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  sts_t      sts,
  output cmd_t      cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_CONF;
      end
      S_CONF: begin
        cmd.conf  = 1'b1;
        idx_nxt   = 3'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_OFS;
      end
      S_OFS: begin
        cmd.ofs   = 1'b1;
        state_nxt = S_PLO;
      end
      S_PLO: begin
        cmd.plo   = 1'b1;
        state_nxt = S_PHI;
      end
      S_PHI: begin
        cmd.phi = 1'b1;
        if (idx_r == 3'd7) begin
          state_nxt = S_GATE;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_MUL;
        end
      end
      S_GATE: begin
        cmd.gate  = 1'b1;
        state_nxt = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/pgqd_dp.sv
// Datapath of the plate grid quad decoder: sigmoid table, corner multipliers,
// box gate, kept quad and output register. Depends on pgqd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pgqd_dp import pgqd_pkg::*; #(
  parameter int GRID_DIM_MAX    = GRID_DIM_MAX_DEF,
  parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cfg_t             cfg,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  wire logic [5:0]  in_cell_col,
  input  wire logic [5:0]  in_cell_row,
  input  wire logic signed [15:0] in_score_raw,
  input  wire logic signed [15:0] in_aff_xx,
  input  wire logic signed [15:0] in_aff_xy,
  input  wire logic signed [15:0] in_aff_xt,
  input  wire logic signed [15:0] in_aff_yx,
  input  wire logic signed [15:0] in_aff_yy,
  input  wire logic signed [15:0] in_aff_yt,
  input  wire logic        in_last_cell,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_corner [8],
  output logic [15:0]      out_best_score,
  output logic             out_found
);

  localparam int SIG_AW = $clog2(SIGMOID_ENTRIES);
  localparam int IDX_PW = 12 + $clog2(SIGMOID_ENTRIES + 1);

  typedef logic [15:0] sig_arr_t [SIGMOID_ENTRIES];

  function automatic sig_arr_t build_table();
    sig_arr_t t;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) t[i] = sigmoid_entry(i, SIGMOID_ENTRIES);
    return t;
  endfunction

  localparam sig_arr_t SIG_TABLE = build_table();

  // captured cell
  logic [5:0]         col_r, row_r;
  logic signed [15:0] score_r, xx_r, xy_r, xt_r, yx_r, yy_r, yt_r;
  logic               last_r, rej_r;
  logic [SIG_AW-1:0]  sidx_r;
  logic [15:0]        sig_r, conf_r;
  // corner pipeline
  logic signed [35:0] p1_r;
  logic signed [36:0] v1_r;
  logic [33:0]        acc_r;
  logic [15:0]        c_r [8];
  logic [15:0]        lox_r, hix_r, loy_r, hiy_r;
  // kept quad
  logic [15:0]        best_c_r [8];
  logic [15:0]        best_prob_r;
  logic               have_r;
  // output register
  logic               out_valid_r;
  logic [15:0]        out_c_r [8];
  logic [15:0]        out_score_r;
  logic               out_found_r;

  // score clamp and table index
  logic signed [15:0] s_clamp;
  logic [11:0]        s_ofs;
  logic [IDX_PW-1:0]  s_prod;
  logic               bad_cell;

  always_comb begin
    if (in_score_raw < -16'sd2048)     s_clamp = -16'sd2048;
    else if (in_score_raw > 16'sd2047) s_clamp = 16'sd2047;
    else                               s_clamp = in_score_raw;
    s_ofs    = 12'(s_clamp + 16'sd2048);
    s_prod   = IDX_PW'(s_ofs) * IDX_PW'(SIGMOID_ENTRIES);
    bad_cell = (32'(in_cell_col) >= GRID_DIM_MAX) || (32'(in_cell_row) >= GRID_DIM_MAX);
  end

  // corner operand selection
  logic               axis;
  logic [1:0]         cn;
  logic signed [15:0] ta, tb, tt;
  logic signed [18:0] ra, rb, rsum;
  logic [15:0]        ppc;
  logic [5:0]         cell_pos;
  logic signed [35:0] hp;
  logic signed [53:0] vfull, vrnd;
  logic [32:0]        q;
  logic [15:0]        cval;
  logic [15:0]        conf_nxt;
  logic               conf_rej;

  always_comb begin
    axis     = cmd.idx[2];
    cn       = cmd.idx[1:0];
    ta       = axis ? yx_r : xx_r;
    tb       = axis ? yy_r : xy_r;
    tt       = axis ? yt_r : xt_r;
    ppc      = axis ? cfg.ppc_y : cfg.ppc_x;
    cell_pos = axis ? row_r : col_r;
    // corner order: top-left, top-right, bottom-right, bottom-left
    ra    = (cn == 2'd1 || cn == 2'd2) ? 19'(ta) : -19'(ta);
    rb    = (cn == 2'd2 || cn == 2'd3) ? 19'(tb) : -19'(tb);
    rsum  = ra + rb + (19'(tt) <<< 1);
    hp    = $signed(v1_r[36:18]) * $signed({1'b0, ppc});
    vfull = ($signed(54'(hp)) <<< 18) + $signed({20'd0, acc_r});
    vrnd  = vfull + 54'sd1048576;
    q     = vrnd[53:21];
    cval  = (|q[32:16]) ? 16'hFFFF : q[15:0];
    if (cfg.logit_mode) begin
      conf_nxt = sig_r;
      conf_rej = 1'b0;
    end else begin
      conf_nxt = {score_r[14:0], 1'b0};
      conf_rej = score_r[15];
    end
  end

  logic box_rej, take;
  always_comb begin
    box_rej = ((hix_r - lox_r) < cfg.min_box_w) || ((hiy_r - loy_r) < cfg.min_box_h);
    take    = !rej_r && !box_rej && (!have_r || conf_r > best_prob_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r   <= in_cell_col;
      row_r   <= in_cell_row;
      score_r <= in_score_raw;
      xx_r    <= in_aff_xx[15] ? 16'sd0 : in_aff_xx;
      xy_r    <= in_aff_xy;
      xt_r    <= in_aff_xt;
      yx_r    <= in_aff_yx;
      yy_r    <= in_aff_yy[15] ? 16'sd0 : in_aff_yy;
      yt_r    <= in_aff_yt;
      last_r  <= in_last_cell;
      sidx_r  <= SIG_AW'(s_prod >> 12);
    end
    if (cmd.look) sig_r <= SIG_TABLE[sidx_r];
    if (cmd.conf) conf_r <= conf_nxt;
    if (cmd.mul)  p1_r <= rsum * $signed({1'b0, cfg.side_scale});
    if (cmd.ofs)  v1_r <= 37'(p1_r) + $signed({14'd0, cell_pos, 1'b1, 16'd0});
    if (cmd.plo)  acc_r <= 34'(v1_r[17:0]) * 34'(ppc);
    if (cmd.phi) begin
      c_r[cmd.idx] <= cval;
      if (!axis) begin
        lox_r <= (cn == 2'd0 || cval < lox_r) ? cval : lox_r;
        hix_r <= (cn == 2'd0 || cval > hix_r) ? cval : hix_r;
      end else begin
        loy_r <= (cn == 2'd0 || cval < loy_r) ? cval : loy_r;
        hiy_r <= (cn == 2'd0 || cval > hiy_r) ? cval : hiy_r;
      end
    end
    if (cmd.emit) begin
      for (int j = 0; j < 8; j++) out_c_r[j] <= have_r ? best_c_r[j] : 16'd0;
      out_score_r <= have_r ? best_prob_r : 16'd0;
      out_found_r <= have_r;
    end
    if (cmd.gate && take) begin
      for (int j = 0; j < 8; j++) best_c_r[j] <= c_r[j];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rej_r       <= 1'b0;
      have_r      <= 1'b0;
      best_prob_r <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) rej_r <= bad_cell;
      if (cmd.conf) rej_r <= rej_r || conf_rej || (conf_nxt < cfg.min_confidence);
      // a negative exact corner rejects the cell
      if (cmd.phi && vfull[53]) rej_r <= 1'b1;
      if (cmd.gate && take) begin
        best_prob_r <= conf_r;
        have_r      <= 1'b1;
      end
      if (cmd.emit) begin
        have_r      <= 1'b0;
        best_prob_r <= 16'd0;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.last       = last_r;
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_corner     = out_c_r;
  assign out_best_score = out_score_r;
  assign out_found      = out_found_r;

endmodule
`default_nettype wire

>>> rtl/core/plate_grid_quad_decoder.sv
// Top level of the plate grid quad decoder: configuration port, sequencer and datapath.
// Depends on pgqd_pkg, pgqd_cfg, pgqd_ctrl and pgqd_dp.
//
//   channel  | signals                          | transfer when
//   ---------+----------------------------------+-----------------------------------
//   in       | in_valid / in_stall, cell fields | in_valid && !in_stall
//   out      | out_valid / out_stall, quad      | out_valid && !out_stall
//   cfg      | psel penable pwrite paddr pwdata | psel && penable && pwrite
//
// Each cell goes through load, table read, threshold, eight corners of multiply,
// offset, low and high product steps, and the box gate; a new cell is taken only once
// the last one is through. A last cell then moves the quad into the output register,
// and waits while an earlier result is still held; a held result is kept while the
// next cell runs. Synchronous active-low reset restores register defaults and clears
// the kept quad. The sigmoid table is constant logic and needs no fill.
`timescale 1ns / 1ps
`default_nettype none
module plate_grid_quad_decoder import pgqd_pkg::*; #(
  parameter int GRID_DIM_MAX    = GRID_DIM_MAX_DEF,
  parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [5:0]        in_cell_col,
  input  wire logic [5:0]        in_cell_row,
  input  wire logic signed [15:0] in_score_raw,
  input  wire logic signed [15:0] in_aff_xx,
  input  wire logic signed [15:0] in_aff_xy,
  input  wire logic signed [15:0] in_aff_xt,
  input  wire logic signed [15:0] in_aff_yx,
  input  wire logic signed [15:0] in_aff_yy,
  input  wire logic signed [15:0] in_aff_yt,
  input  wire logic              in_last_cell,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [15:0]            out_corner0_x,
  output logic [15:0]            out_corner1_x,
  output logic [15:0]            out_corner2_x,
  output logic [15:0]            out_corner3_x,
  output logic [15:0]            out_corner0_y,
  output logic [15:0]            out_corner1_y,
  output logic [15:0]            out_corner2_y,
  output logic [15:0]            out_corner3_y,
  output logic [15:0]            out_best_score,
  output logic                   out_found
);

  cfg_t        cfg;
  cmd_t        cmd;
  sts_t        sts;
  logic [15:0] corner [8];

  assign pready = 1'b1;

  pgqd_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  pgqd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .sts, .cmd
  );

  pgqd_dp #(
    .GRID_DIM_MAX   (GRID_DIM_MAX),
    .SIGMOID_ENTRIES(SIGMOID_ENTRIES)
  ) u_dp (
    .clk, .rst_n, .cfg, .cmd, .sts,
    .in_cell_col, .in_cell_row, .in_score_raw,
    .in_aff_xx, .in_aff_xy, .in_aff_xt, .in_aff_yx, .in_aff_yy, .in_aff_yt,
    .in_last_cell, .out_valid, .out_stall,
    .out_corner(corner), .out_best_score, .out_found
  );

  assign out_corner0_x = corner[0];
  assign out_corner1_x = corner[1];
  assign out_corner2_x = corner[2];
  assign out_corner3_x = corner[3];
  assign out_corner0_y = corner[4];
  assign out_corner1_y = corner[5];
  assign out_corner2_y = corner[6];
  assign out_corner3_y = corner[7];

endmodule
`default_nettype wire
